>>> rtl/pn_junction_voltage_limiter_assert.svh
// assertion macros for the junction voltage limiter
// used by the port checker; no other dependencies
`ifndef PN_JUNCTION_VOLTAGE_LIMITER_ASSERT_SVH
`define PN_JUNCTION_VOLTAGE_LIMITER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PJL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pjl assertion failed");

// next-cycle implication, disabled in reset
`define PJL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pjl assertion failed");

`endif

>>> rtl/pjl_pkg.sv
// shared types and constants of the junction voltage limiter
// no dependencies
package pjl_pkg;

   // how the back end forms the result
   localparam logic [1:0] MODE_PASS     = 2'd0;
   localparam logic [1:0] MODE_LOG_OLD  = 2'd1;
   localparam logic [1:0] MODE_LOG_ZERO = 2'd2;

   // ln2 as Q1.63, split in two 32-bit halves
   localparam logic [31:0] LN2_HI = 32'h58B9_0BFB;
   localparam logic [31:0] LN2_LO = 32'hE8E7_BCD6;

   localparam logic [63:0] TV_RESET = 64'd433731;
   localparam logic [63:0] VC_RESET = 64'd10066330;

   typedef struct packed {
      logic       valid;
      logic [1:0] mode;
      logic       flag;
      logic       step_neg;
   } pjl_ctl_type;

endpackage

>>> rtl/pjl_front.sv
// front end: step, branch decision, clamp bound, log argument normalization
// depends on pjl_pkg
module pjl_front import pjl_pkg::*; #(
   parameter int W = 32,
   parameter int F = 24,
   localparam int XW = W + 1,
   localparam int PW = $clog2(XW)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                in_valid,
   input  logic [W-1:0]        vnew,
   input  logic [W-1:0]        vold,
   input  logic [W-2:0]        tv_raw,
   input  logic [W-1:0]        vcrit,
   output pjl_ctl_type         ctl_out,
   output logic [W-1:0]        vold_out,
   output logic [W-2:0]        vt_out,
   output logic [W-1:0]        res_out,
   output logic [PW-1:0]       px_out,
   output logic [PW-1:0]       pv_out,
   output logic [31:0]         mx_out,
   output logic [31:0]         mv_out
);

   localparam logic signed [W+1:0] BMAX = {3'b000, {(W-1){1'b1}}};
   localparam logic signed [W+1:0] BMIN = {3'b111, {(W-1){1'b0}}};

   logic [W-2:0]          vt_a;
   logic [W-1:0]          two_vt;
   logic [W:0]            step;
   logic                  step_neg;
   logic [W:0]            mag;
   logic                  log_c;
   logic                  vold_pos;
   logic                  vnew_pos;
   logic [XW-1:0]         x_a;
   logic signed [W+1:0]   vold_x;
   logic signed [W+1:0]   vnew_x;
   logic signed [W+1:0]   one_x;
   logic signed [W+1:0]   bound;
   logic [W-1:0]          bound_sat;
   pjl_ctl_type           ctl_a;
   logic [W-1:0]          res_a;

   pjl_ctl_type           a_ctl_ff;
   logic [W-1:0]          a_vold_ff;
   logic [W-2:0]          a_vt_ff;
   logic [XW-1:0]         a_x_ff;
   logic [W-1:0]          a_res_ff;

   logic [XW-1:0]         v_ext;
   logic [PW-1:0]         px_in;
   logic [PW-1:0]         pv_in;
   logic [XW+30:0]        wx;
   logic [XW+30:0]        wv;

   pjl_ctl_type           b_ctl_ff;
   logic [W-1:0]          b_vold_ff;
   logic [W-2:0]          b_vt_ff;
   logic [W-1:0]          b_res_ff;
   logic [PW-1:0]         b_px_ff;
   logic [PW-1:0]         b_pv_ff;
   logic [31:0]           b_mx_ff;
   logic [31:0]           b_mv_ff;

   function automatic logic [PW-1:0] msb_pos(input logic [XW-1:0] v);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < XW; i++) begin
         if (v[i]) p = PW'(i);
      end
      return p;
   endfunction

   always_comb begin
      vt_a     = (tv_raw == '0) ? (W-1)'(1) : tv_raw;
      two_vt   = {vt_a, 1'b0};
      step     = {vnew[W-1], vnew} - {vold[W-1], vold};
      step_neg = step[W];
      mag      = step_neg ? (~step + (W+1)'(1)) : step;
      log_c    = ($signed(vnew) > $signed(vcrit)) && (mag > {1'b0, two_vt});
      vold_pos = !vold[W-1] && (vold != '0);
      vnew_pos = !vnew[W-1] && (vnew != '0);
      if (vold_pos) begin
         x_a = step_neg ? (mag + {1'b0, two_vt}) : (mag - {1'b0, two_vt});
      end else begin
         x_a = {1'b0, vnew};
      end
      vold_x = {{2{vold[W-1]}}, vold};
      vnew_x = {{2{vnew[W-1]}}, vnew};
      one_x  = (W+2)'(1) <<< F;
      bound  = vold_pos ? (-vold_x - one_x) : (vold_x + vold_x - one_x);
      if (bound > BMAX) begin
         bound_sat = BMAX[W-1:0];
      end else if (bound < BMIN) begin
         bound_sat = BMIN[W-1:0];
      end else begin
         bound_sat = bound[W-1:0];
      end
      ctl_a.valid    = in_valid;
      ctl_a.step_neg = step_neg;
      ctl_a.mode     = MODE_PASS;
      ctl_a.flag     = 1'b0;
      res_a          = vnew;
      if (log_c) begin
         ctl_a.flag = 1'b1;
         if (vold_pos) begin
            ctl_a.mode = MODE_LOG_OLD;
         end else if (vnew_pos) begin
            ctl_a.mode = MODE_LOG_ZERO;
         end else begin
            // log of a non-positive value
            res_a = BMIN[W-1:0];
         end
      end else if (vnew[W-1] && (vnew_x < bound)) begin
         ctl_a.flag = 1'b1;
         res_a      = bound_sat;
      end
   end

   always_comb begin
      v_ext = {2'b00, a_vt_ff};
      px_in = msb_pos(a_x_ff);
      pv_in = msb_pos(v_ext);
      // leading one lands on bit 31
      wx    = {a_x_ff, 31'b0} >> px_in;
      wv    = {v_ext, 31'b0} >> pv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else if (load) begin
         a_ctl_ff <= ctl_a;
         b_ctl_ff <= a_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_vold_ff <= vold;
         a_vt_ff   <= vt_a;
         a_x_ff    <= x_a;
         a_res_ff  <= res_a;
         b_vold_ff <= a_vold_ff;
         b_vt_ff   <= a_vt_ff;
         b_res_ff  <= a_res_ff;
         b_px_ff   <= px_in;
         b_pv_ff   <= pv_in;
         b_mx_ff   <= wx[31:0];
         b_mv_ff   <= wv[31:0];
      end
   end

   assign ctl_out  = b_ctl_ff;
   assign vold_out = b_vold_ff;
   assign vt_out   = b_vt_ff;
   assign res_out  = b_res_ff;
   assign px_out   = b_px_ff;
   assign pv_out   = b_pv_ff;
   assign mx_out   = b_mx_ff;
   assign mv_out   = b_mv_ff;

endmodule

>>> rtl/pjl_sq_cell.sv
// one log2 fraction cell: squares both mantissas and emits one fraction bit each
// depends on pjl_pkg
module pjl_sq_cell import pjl_pkg::*; #(
   parameter int F  = 24,
   parameter int SW = 100
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  pjl_ctl_type   ctl_in,
   input  logic [SW-1:0] side_in,
   input  logic [31:0]   ma_in,
   input  logic [31:0]   mb_in,
   input  logic [F-1:0]  fa_in,
   input  logic [F-1:0]  fb_in,
   output pjl_ctl_type   ctl_out,
   output logic [SW-1:0] side_out,
   output logic [31:0]   ma_out,
   output logic [31:0]   mb_out,
   output logic [F-1:0]  fa_out,
   output logic [F-1:0]  fb_out
);

   logic [63:0]   sqa;
   logic [63:0]   sqb;
   logic [32:0]   sa;
   logic [32:0]   sb;
   pjl_ctl_type   ctl_ff;
   logic [SW-1:0] side_ff;
   logic [31:0]   ma_ff;
   logic [31:0]   mb_ff;
   logic [F-1:0]  fa_ff;
   logic [F-1:0]  fb_ff;

   always_comb begin
      sqa = 64'(ma_in) * 64'(ma_in);
      sqb = 64'(mb_in) * 64'(mb_in);
      sa  = sqa[63:31];
      sb  = sqb[63:31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff <= side_in;
         // square reaching 2.0 gives a one bit and renormalizes
         ma_ff   <= sa[32] ? sa[32:1] : sa[31:0];
         mb_ff   <= sb[32] ? sb[32:1] : sb[31:0];
         fa_ff   <= {fa_in[F-2:0], sa[32]};
         fb_ff   <= {fb_in[F-2:0], sb[32]};
      end
   end

   assign ctl_out  = ctl_ff;
   assign side_out = side_ff;
   assign ma_out   = ma_ff;
   assign mb_out   = mb_ff;
   assign fa_out   = fa_ff;
   assign fb_out   = fb_ff;

endmodule

>>> rtl/pjl_back.sv
// back end: log2 to ln scaling, thermal voltage product, final add and saturation
// depends on pjl_pkg
module pjl_back import pjl_pkg::*; #(
   parameter int W = 32,
   parameter int F = 24,
   localparam int XW = W + 1,
   localparam int PW = $clog2(XW)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  pjl_ctl_type   ctl_in,
   input  logic [W-1:0]  vold,
   input  logic [W-2:0]  vt,
   input  logic [W-1:0]  res_alt,
   input  logic [PW-1:0] px,
   input  logic [PW-1:0] pv,
   input  logic [F-1:0]  fa,
   input  logic [F-1:0]  fb,
   output pjl_ctl_type   ctl_out,
   output logic [W-1:0]  res_out
);

   localparam int LW  = F + 8;
   localparam int MW  = LW - 1;
   localparam int YW  = LW + 2;
   localparam int PRW = (YW - 1) + (W - 1);
   localparam int RW  = PRW + 2;
   localparam logic [YW-1:0] TWO  = YW'(2) << F;
   localparam logic signed [RW-1:0] RMAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [RW-1:0] RMIN = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

   // stage 1: log2 value and ln2 partial products
   logic [LW-1:0]    l2a;
   logic [LW-1:0]    l2b;
   logic [LW-1:0]    ga;
   logic [LW-1:0]    gb;
   pjl_ctl_type      c1_ctl_ff;
   logic [W-1:0]     c1_vold_ff;
   logic [W-2:0]     c1_vt_ff;
   logic [W-1:0]     c1_res_ff;
   logic             c1_na_ff;
   logic             c1_nb_ff;
   logic [MW+31:0]   c1_ah_ff;
   logic [MW+31:0]   c1_al_ff;
   logic [MW+31:0]   c1_bh_ff;
   logic [MW+31:0]   c1_bl_ff;

   // stage 2: ln values
   logic [MW+31:0]   sa;
   logic [MW+31:0]   sb;
   logic [LW-1:0]    lna;
   logic [LW-1:0]    lnb;
   pjl_ctl_type      c2_ctl_ff;
   logic [W-1:0]     c2_vold_ff;
   logic [W-2:0]     c2_vt_ff;
   logic [W-1:0]     c2_res_ff;
   logic [LW-1:0]    c2_lna_ff;
   logic [LW-1:0]    c2_lnb_ff;

   // stage 3: y in sign and magnitude
   logic [YW-1:0]    diff;
   logic [YW-1:0]    y;
   pjl_ctl_type      c3_ctl_ff;
   logic [W-1:0]     c3_vold_ff;
   logic [W-2:0]     c3_vt_ff;
   logic [W-1:0]     c3_res_ff;
   logic             c3_yn_ff;
   logic [YW-2:0]    c3_ym_ff;

   // stage 4: product with the thermal voltage
   pjl_ctl_type      c4_ctl_ff;
   logic [W-1:0]     c4_vold_ff;
   logic [W-1:0]     c4_res_ff;
   logic             c4_yn_ff;
   logic [PRW-1:0]   c4_prod_ff;

   // stage 5: result register
   logic [PRW-1:0]   dm;
   logic [RW-1:0]    d;
   logic [RW-1:0]    vold_x;
   logic signed [RW-1:0] sum;
   logic [W-1:0]     res_in;
   pjl_ctl_type      c5_ctl_ff;
   logic [W-1:0]     c5_res_ff;

   always_comb begin
      l2a = ((LW'(px) - LW'(F)) << F) + LW'(fa);
      l2b = ((LW'(pv) - LW'(F)) << F) + LW'(fb);
      ga  = l2a[LW-1] ? (~l2a + LW'(1)) : l2a;
      gb  = l2b[LW-1] ? (~l2b + LW'(1)) : l2b;
   end

   always_comb begin
      // (g * ln2) >> 63 from the two halves, truncated toward zero
      sa  = c1_ah_ff + (c1_al_ff >> 32);
      sb  = c1_bh_ff + (c1_bl_ff >> 32);
      lna = c1_na_ff ? (~LW'(sa >> 31) + LW'(1)) : LW'(sa >> 31);
      lnb = c1_nb_ff ? (~LW'(sb >> 31) + LW'(1)) : LW'(sb >> 31);
   end

   always_comb begin
      diff = {{2{c2_lna_ff[LW-1]}}, c2_lna_ff} - {{2{c2_lnb_ff[LW-1]}}, c2_lnb_ff};
      y    = (c2_ctl_ff.mode == MODE_LOG_OLD) ? (diff + TWO) : diff;
   end

   always_comb begin
      dm     = c4_prod_ff >> F;
      d      = c4_yn_ff ? (~RW'(dm) + RW'(1)) : RW'(dm);
      vold_x = {{(RW-W){c4_vold_ff[W-1]}}, c4_vold_ff};
      case (c4_ctl_ff.mode)
         MODE_LOG_OLD: begin
            sum = c4_ctl_ff.step_neg ? $signed(vold_x - d) : $signed(vold_x + d);
         end
         MODE_LOG_ZERO: begin
            sum = $signed(d);
         end
         default: begin
            sum = $signed({{(RW-W){c4_res_ff[W-1]}}, c4_res_ff});
         end
      endcase
      if (sum > RMAX) begin
         res_in = RMAX[W-1:0];
      end else if (sum < RMIN) begin
         res_in = RMIN[W-1:0];
      end else begin
         res_in = sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ctl_ff <= '0;
         c2_ctl_ff <= '0;
         c3_ctl_ff <= '0;
         c4_ctl_ff <= '0;
         c5_ctl_ff <= '0;
      end else if (load) begin
         c1_ctl_ff <= ctl_in;
         c2_ctl_ff <= c1_ctl_ff;
         c3_ctl_ff <= c2_ctl_ff;
         c4_ctl_ff <= c3_ctl_ff;
         c5_ctl_ff <= c4_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         c1_vold_ff <= vold;
         c1_vt_ff   <= vt;
         c1_res_ff  <= res_alt;
         c1_na_ff   <= l2a[LW-1];
         c1_nb_ff   <= l2b[LW-1];
         c1_ah_ff   <= (MW+32)'(ga[MW-1:0]) * (MW+32)'(LN2_HI);
         c1_al_ff   <= (MW+32)'(ga[MW-1:0]) * (MW+32)'(LN2_LO);
         c1_bh_ff   <= (MW+32)'(gb[MW-1:0]) * (MW+32)'(LN2_HI);
         c1_bl_ff   <= (MW+32)'(gb[MW-1:0]) * (MW+32)'(LN2_LO);

         c2_vold_ff <= c1_vold_ff;
         c2_vt_ff   <= c1_vt_ff;
         c2_res_ff  <= c1_res_ff;
         c2_lna_ff  <= lna;
         c2_lnb_ff  <= lnb;

         c3_vold_ff <= c2_vold_ff;
         c3_vt_ff   <= c2_vt_ff;
         c3_res_ff  <= c2_res_ff;
         c3_yn_ff   <= y[YW-1];
         c3_ym_ff   <= y[YW-1] ? (~y[YW-2:0] + (YW-1)'(1)) : y[YW-2:0];

         c4_vold_ff <= c3_vold_ff;
         c4_res_ff  <= c3_res_ff;
         c4_yn_ff   <= c3_yn_ff;
         c4_prod_ff <= PRW'(c3_ym_ff) * PRW'(c3_vt_ff);

         c5_res_ff  <= res_in;
      end
   end

   assign ctl_out = c5_ctl_ff;
   assign res_out = c5_res_ff;

endmodule

>>> rtl/pn_junction_voltage_limiter.sv
// Newton-step junction voltage limiter with logarithmic compression
// Channels: req_ carries proposed and previous voltage (signed fixed point,
// FRAC_BITS fraction bits), rsp_ carries the limited voltage and a flag that
// says whether limiting changed the step. Both use valid/ready.
// An APB-style port holds thermal_voltage (0x0) and critical_voltage (0x4,
// or 0x8 when VOLT_WIDTH exceeds 32); write them only while no item is in flight.
// The pipe has two front stages, one squaring cell per fraction bit of the
// log2 chain, and five back stages; the cell chain sets the latency.
// Throughput is one item per cycle while the output is not stalled.
// All stages move together; when rsp_ready is low with a result waiting, the
// whole pipe holds and req_ready drops until the result is taken.
// Reset empties the pipe and loads the register defaults.
// Depends on pjl_pkg, pjl_front, pjl_sq_cell and pjl_back.
module pn_junction_voltage_limiter import pjl_pkg::*; #(
   parameter int VOLT_WIDTH = 32,
   parameter int FRAC_BITS  = 24,
   localparam int CDW = (VOLT_WIDTH > 32) ? 64 : 32,
   localparam int AW  = (VOLT_WIDTH > 32) ? 4 : 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VOLT_WIDTH-1:0] req_proposed_voltage,
   input  logic [VOLT_WIDTH-1:0] req_previous_voltage,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VOLT_WIDTH-1:0] rsp_limited_voltage,
   output logic                  rsp_was_limited,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [AW-1:0]         paddr,
   input  logic [CDW-1:0]        pwdata,
   output logic [CDW-1:0]        prdata,
   output logic                  pready
);

   localparam int W  = VOLT_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = $clog2(W + 1);
   localparam int SW = W + (W - 1) + W + 2 * PW;

   logic [W-2:0]   tv_ff;
   logic [W-1:0]   vc_ff;
   logic           load;

   pjl_ctl_type    f_ctl;
   logic [W-1:0]   f_vold;
   logic [W-2:0]   f_vt;
   logic [W-1:0]   f_res;
   logic [PW-1:0]  f_px;
   logic [PW-1:0]  f_pv;

   pjl_ctl_type    cc  [0:F];
   logic [SW-1:0]  sd  [0:F];
   logic [31:0]    ma  [0:F];
   logic [31:0]    mb  [0:F];
   logic [F-1:0]   fa  [0:F];
   logic [F-1:0]   fb  [0:F];

   logic [W-1:0]   t_vold;
   logic [W-2:0]   t_vt;
   logic [W-1:0]   t_res;
   logic [PW-1:0]  t_px;
   logic [PW-1:0]  t_pv;
   pjl_ctl_type    o_ctl;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= TV_RESET[W-2:0];
         vc_ff <= VC_RESET[W-1:0];
      end else if (psel && penable && pwrite) begin
         if (paddr[AW-1]) begin
            vc_ff <= pwdata[W-1:0];
         end else begin
            tv_ff <= pwdata[W-2:0];
         end
      end
   end

   assign prdata = paddr[AW-1] ? CDW'(vc_ff) : CDW'(tv_ff);
   assign pready = 1'b1;

   assign load      = !o_ctl.valid || rsp_ready;
   assign req_ready = load;

   pjl_front #(.W(W), .F(F)) u_front (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .in_valid (req_valid),
      .vnew     (req_proposed_voltage),
      .vold     (req_previous_voltage),
      .tv_raw   (tv_ff),
      .vcrit    (vc_ff),
      .ctl_out  (f_ctl),
      .vold_out (f_vold),
      .vt_out   (f_vt),
      .res_out  (f_res),
      .px_out   (f_px),
      .pv_out   (f_pv),
      .mx_out   (ma[0]),
      .mv_out   (mb[0])
   );

   assign cc[0] = f_ctl;
   assign sd[0] = {f_vold, f_vt, f_res, f_px, f_pv};
   assign fa[0] = '0;
   assign fb[0] = '0;

   for (genvar i = 0; i < F; i++) begin : g_cell
      pjl_sq_cell #(.F(F), .SW(SW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .load     (load),
         .ctl_in   (cc[i]),
         .side_in  (sd[i]),
         .ma_in    (ma[i]),
         .mb_in    (mb[i]),
         .fa_in    (fa[i]),
         .fb_in    (fb[i]),
         .ctl_out  (cc[i+1]),
         .side_out (sd[i+1]),
         .ma_out   (ma[i+1]),
         .mb_out   (mb[i+1]),
         .fa_out   (fa[i+1]),
         .fb_out   (fb[i+1])
      );
   end

   assign {t_vold, t_vt, t_res, t_px, t_pv} = sd[F];

   pjl_back #(.W(W), .F(F)) u_back (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .ctl_in  (cc[F]),
      .vold    (t_vold),
      .vt      (t_vt),
      .res_alt (t_res),
      .px      (t_px),
      .pv      (t_pv),
      .fa      (fa[F]),
      .fb      (fb[F]),
      .ctl_out (o_ctl),
      .res_out (rsp_limited_voltage)
   );

   assign rsp_valid       = o_ctl.valid;
   assign rsp_was_limited = o_ctl.flag;

endmodule

>>> rtl/pjl_check.sv
// port-level checker for the junction voltage limiter, bound to the top level
// depends on pn_junction_voltage_limiter_assert.svh
`include "pn_junction_voltage_limiter_assert.svh"

module pjl_check #(
   parameter int W = 32
) (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [W-1:0] rsp_limited_voltage,
   input logic         rsp_was_limited
);

   // a waiting result holds its value and flag
   `PJL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_limited_voltage) && $stable(rsp_was_limited))

   // a blocked output stalls the input side
   `PJL_ASSERT_NOW(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // an empty output never stalls the input side
   `PJL_ASSERT_NOW(a_free_accepts, clock, reset, !rsp_valid, req_ready)

   // the pipe comes out of reset empty
   `PJL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind pn_junction_voltage_limiter pjl_check #(.W(VOLT_WIDTH)) u_pjl_check (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_limited_voltage (rsp_limited_voltage),
   .rsp_was_limited     (rsp_was_limited)
);

>>> tb/pn_junction_voltage_limiter_tb.sv
// testbench for pn_junction_voltage_limiter: directed and random voltage pairs
// under several threshold settings, checked against a local limiter predictor
// depends on pjl_pkg and the pn_junction_voltage_limiter rtl
module pn_junction_voltage_limiter_tb;
   import pjl_pkg::*;

   localparam int VW = 32;
   localparam int FB = 24;
   localparam logic [63:0] LN2_Q63 = {LN2_HI, LN2_LO};
   localparam longint VMAX = 64'sh7FFF_FFFF;
   localparam longint VMIN = -64'sh8000_0000;
   localparam logic [2:0] ADDR_THERMAL  = 3'd0;
   localparam logic [2:0] ADDR_CRITICAL = 3'd4;

   typedef struct {
      logic [VW-1:0] voltage;
      logic          limited;
   } limit_result_type;

   class limiter_scoreboard_type;
      logic [30:0]      thermal;
      logic [VW-1:0]    critical;
      limit_result_type pending[$];
      int               errors;

      function new();
         thermal  = TV_RESET[30:0];
         critical = VC_RESET[VW-1:0];
         errors   = 0;
      endfunction

      static function longint clamp65(logic signed [64:0] s);
         if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
         if (s < -65'sh0_8000_0000_0000_0000) return -64'sh8000_0000_0000_0000;
         return longint'(s[63:0]);
      endfunction

      static function longint add_sat(longint a, longint b);
         return clamp65(65'(signed'(a)) + 65'(signed'(b)));
      endfunction

      static function longint sub_sat(longint a, longint b);
         return clamp65(65'(signed'(a)) - 65'(signed'(b)));
      endfunction

      // signed times unsigned, shifted right toward zero, saturated
      static function longint scaled_mul(longint a, logic [63:0] b, int s);
         logic [63:0]  amag;
         logic [127:0] prod;
         amag = (a < 0) ? -a : a;
         prod = ({64'd0, amag} * {64'd0, b}) >> s;
         if (a >= 0) return (prod > 128'h7FFF_FFFF_FFFF_FFFF) ?
            64'sh7FFF_FFFF_FFFF_FFFF : longint'(prod[63:0]);
         if (prod >= 128'h8000_0000_0000_0000) return -64'sh8000_0000_0000_0000;
         return -longint'(prod[63:0]);
      endfunction

      static function longint natural_log(logic [63:0] x);
         int          msb;
         logic [63:0] mant;
         longint      frac;
         longint      log2v;
         msb  = 63;
         frac = 0;
         while (x[msb] == 1'b0) msb--;
         mant = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
         for (int i = 0; i < FB; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= 64'h1_0000_0000) begin
               frac = frac | 1;
               mant = mant >> 1;
            end
         end
         log2v = longint'(msb - FB) * (64'sd1 <<< FB) + frac;
         return scaled_mul(log2v, LN2_Q63, 63);
      endfunction

      function limit_result_type limit(logic [VW-1:0] prop, logic [VW-1:0] prev);
         limit_result_type r;
         longint vnew, vold, vcrit, stp, res, y, d, bound, one;
         logic [63:0] vt, two_vt, mag, x;
         vnew  = longint'(signed'(prop));
         vold  = longint'(signed'(prev));
         vcrit = longint'(signed'(critical));
         vt    = (thermal == 0) ? 64'd1 : {33'd0, thermal};
         two_vt = vt + vt;
         one   = 64'sd1 <<< FB;
         stp   = sub_sat(vnew, vold);
         mag   = (stp < 0) ? -stp : stp;
         res   = vnew;
         r.limited = 1'b0;
         if (vnew > vcrit && mag > two_vt) begin
            r.limited = 1'b1;
            if (vold > 0) begin
               x = (stp > 0) ? mag - two_vt : mag + two_vt;
               y = add_sat(2 * one, sub_sat(natural_log(x), natural_log(vt)));
               d = scaled_mul(y, vt, FB);
               res = (stp > 0) ? add_sat(vold, d) : sub_sat(vold, d);
            end else if (vnew > 0) begin
               y = sub_sat(natural_log(vnew), natural_log(vt));
               res = scaled_mul(y, vt, FB);
            end else begin
               res = VMIN;
            end
         end else if (vnew < 0) begin
            bound = (vold > 0) ? sub_sat(-vold, one) : sub_sat(add_sat(vold, vold), one);
            if (vnew < bound) begin
               res = bound;
               r.limited = 1'b1;
            end
         end
         if (res > VMAX) res = VMAX;
         if (res < VMIN) res = VMIN;
         r.voltage = res[VW-1:0];
         return r;
      endfunction

      function void note_item(logic [VW-1:0] prop, logic [VW-1:0] prev);
         pending.insert(pending.size(), limit(prop, prev));
      endfunction

      function void check_result(logic [VW-1:0] volt, logic flag);
         limit_result_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h %b", volt, flag);
            return;
         end
         want = pending.pop_front();
         if (want.voltage !== volt || want.limited !== flag) begin
            errors++;
            if (errors <= 10)
               $display("result mismatch: expected %h %b, got %h %b",
                        want.voltage, want.limited, volt, flag);
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_proposed_voltage = '0;
   logic [VW-1:0] req_previous_voltage = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VW-1:0] rsp_limited_voltage;
   logic          rsp_was_limited;
   logic          psel = 1'b0;
   logic          penable = 1'b0;
   logic          pwrite = 1'b0;
   logic [2:0]    paddr = '0;
   logic [31:0]   pwdata = '0;
   logic [31:0]   prdata;
   logic          pready;

   int tx_idle = 0;
   int rx_idle = 0;
   limiter_scoreboard_type sb = new();

   pn_junction_voltage_limiter DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock)
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle);

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_limited_voltage, rsp_was_limited);

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_THERMAL) sb.thermal = data[30:0];
      else sb.critical = data;
   endtask

   task automatic send_item(logic [VW-1:0] prop, logic [VW-1:0] prev);
      while ($urandom_range(99) < tx_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_proposed_voltage <= prop;
      req_previous_voltage <= prev;
      do @(posedge clock); while (!req_ready);
      sb.note_item(prop, prev);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // mostly steps around a plausible operating point, some fully random pairs
   task automatic send_random(int count);
      logic [VW-1:0] prev, prop;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: begin
               prev = $urandom();
               prop = $urandom();
            end
            1: begin
               prev = VW'(signed'($urandom_range(32'h0400_0000))) - 32'h0100_0000;
               prop = prev + VW'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
            end
            2: begin
               prev = $urandom_range(32'h0200_0000);
               prop = prev + ($urandom() >> $urandom_range(31));
            end
            default: begin
               prev = $urandom() >> $urandom_range(31);
               prop = -($urandom() >> $urandom_range(31));
            end
         endcase
         send_item(prop, prev);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle = 37; rx_idle = 77;
      // extremes and each limiting branch under the reset thresholds
      send_item(32'h7FFF_FFFF, 32'h8000_0000);
      send_item(32'h8000_0000, 32'h7FFF_FFFF);
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'h7FFF_FFFF, 32'h0000_0000);
      send_item(32'h8000_0000, 32'h0000_0000);
      send_item(32'h0000_0000, 32'h7FFF_FFFF);
      send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_item(32'h8000_0000, 32'h8000_0000);
      send_item(32'h0400_0000, 32'h00C0_0000);   // forward step, old positive
      send_item(32'h00A0_0000, 32'h0800_0000);   // backward step above critical
      send_item(32'h0200_0000, 32'hFF00_0000);   // old negative, log from zero
      send_item(32'h0200_0000, 32'h0000_0000);
      send_item(32'hF000_0000, 32'h0100_0000);   // clamp below -old-1
      send_item(32'hFE00_0000, 32'h0100_0000);   // exactly at the bound
      send_item(32'hF000_0000, 32'hFF00_0000);   // clamp below 2*old-1
      send_item(32'hFD00_0000, 32'hFF00_0000);
      send_item(32'h0099_9999, 32'h0000_0000);
      send_item(32'h0099_999B, 32'h0098_0000);
      send_random(95);
      wait_idle();
      // smallest thermal voltage, lowest critical: non-positive log arguments
      csr_write(ADDR_THERMAL, 32'd1);
      csr_write(ADDR_CRITICAL, 32'h8000_0000);
      send_item(32'hFF00_0000, 32'h8000_0000);
      send_item(32'h8000_0001, 32'h0000_0000);
      send_random(110);
      wait_idle();
      tx_idle = 77; rx_idle = 37;
      csr_write(ADDR_THERMAL, 32'h7FFF_FFFF);
      csr_write(ADDR_CRITICAL, 32'h7FFF_FFFF);
      send_random(110);
      wait_idle();
      csr_write(ADDR_THERMAL, 32'h0001_0000);
      csr_write(ADDR_CRITICAL, 32'h0000_0000);
      send_random(110);
      wait_idle();
      tx_idle = 0; rx_idle = 0;
      csr_write(ADDR_THERMAL, $urandom_range(32'h0100_0000, 1));
      csr_write(ADDR_CRITICAL, 32'hFF00_0000);
      send_random(110);
      wait_idle();
      if (sb.errors == 0)
         $display("pn_junction_voltage_limiter: match");
      else
         $display("pn_junction_voltage_limiter: mismatch");
      $finish;
   end

   initial begin
      #5000000;
      $display("pn_junction_voltage_limiter: mismatch");
      $finish;
   end

endmodule
